>>> sv/vhd_pkg.sv
// Shared types, constants and angle table for the vector heading block.
`timescale 1ns / 1ps
`default_nettype none

package vhd_pkg;

    // Field widths
    localparam int COORD_W   = 15;
    localparam int DIFF_W    = 16;
    localparam int HEAD_W    = 15;
    localparam int ACC_W     = 32;
    // Datapath: difference scaled by 2^16 plus CORDIC gain and sign
    localparam int FRAC_W    = 16;
    localparam int DP_W      = 35;
    localparam int MUL_W     = ACC_W + HEAD_W;

    // Step count and table
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // Queue depths
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // Angle constants: binary angle, full circle = 2^32
    localparam logic [ACC_W-1:0]  HALF_TURN_ANGLE = 32'h8000_0000;
    localparam logic [HEAD_W-1:0] FULL_TURN_UNITS = 15'd23040;
    localparam logic [MUL_W-1:0]  ROUND_HALF      = MUL_W'(64'h8000_0000);

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    localparam logic [ACC_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Classified vector, folded into the right half-plane
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     zero_vector;
        logic                     half_turn;
    } vec_item_t;

    // Finished result
    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic              zero_vector;
    } result_t;

endpackage

`default_nettype wire

>>> sv/vector_heading_degrees.sv
// Top level: heading of a departure-to-arrival vector in 1/64 degree units.
//
// Input channel: a transaction is taken at a clock edge with push high and
// full low; it carries departure and arrival points (15-bit signed each).
// Result channel: while empty is low, heading and zero_vector show the
// oldest result; it is taken at an edge with pop high and empty low.
// Each transaction yields exactly one result, in order.
// Throughput: one transaction per cycle, sustained while pop is kept high.
// The front end classifies the vector and writes a two-entry queue; the back
// end is an unrolled CORDIC pipeline of CORDIC_STEPS stages (at most 24) plus
// a load stage and a multiply stage, ending in a two-entry result queue.
// When pop stays low the result queue fills, the whole CORDIC pipeline holds,
// then the middle queue fills and full rises; nothing is dropped.
// Reset clears both queues and all stage valid bits; the block then accepts
// at once. A zero vector gives heading 0 with zero_vector set.
`timescale 1ns / 1ps
`default_nettype none

module vector_heading_degrees #(
    parameter int CORDIC_STEPS = vhd_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic signed [vhd_pkg::COORD_W-1:0] depart_x,
    input  wire logic signed [vhd_pkg::COORD_W-1:0] depart_y,
    input  wire logic signed [vhd_pkg::COORD_W-1:0] arrive_x,
    input  wire logic signed [vhd_pkg::COORD_W-1:0] arrive_y,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [vhd_pkg::HEAD_W-1:0]              heading,
    output logic                                    zero_vector
);

    import vhd_pkg::*;

    vec_item_t front_item;
    vec_item_t mid_item;
    logic      mid_empty;
    logic      mid_pop;
    result_t   back_res;
    result_t   out_res;
    logic      res_push;
    logic      res_full;

    // Classify the incoming vector
    vhd_front u_front (
        .depart_x (depart_x),
        .depart_y (depart_y),
        .arrive_x (arrive_x),
        .arrive_y (arrive_y),
        .item     (front_item)
    );

    // Decoupling queue between front and back
    vhd_fifo #(
        .WIDTH ($bits(vec_item_t)),
        .DEPTH (MID_DEPTH_DEF)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_item),
        .full    (full),
        .pop     (mid_pop),
        .rd_data (mid_item),
        .empty   (mid_empty)
    );

    // CORDIC pipeline
    vhd_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_item),
        .item_valid (!mid_empty),
        .item_pop   (mid_pop),
        .res        (back_res),
        .res_push   (res_push),
        .res_full   (res_full)
    );

    // Result queue facing the receiver
    vhd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH_DEF)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign heading     = out_res.heading;
    assign zero_vector = out_res.zero_vector;

endmodule

`default_nettype wire

>>> sv/vhd_fifo.sv
// Small register-based queue used between the stages of the block.
`timescale 1ns / 1ps
`default_nettype none

module vhd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok && !pop_ok |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not grow on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok && !push_ok |=> count_reg == $past(count_reg) - CW'(1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

>>> sv/vhd_front.sv
// Front end: forms the difference vector and folds it into the right half-plane.
`timescale 1ns / 1ps
`default_nettype none

module vhd_front (
    input  wire logic signed [vhd_pkg::COORD_W-1:0] depart_x,
    input  wire logic signed [vhd_pkg::COORD_W-1:0] depart_y,
    input  wire logic signed [vhd_pkg::COORD_W-1:0] arrive_x,
    input  wire logic signed [vhd_pkg::COORD_W-1:0] arrive_y,
    output vhd_pkg::vec_item_t                      item
);

    import vhd_pkg::*;

    logic signed [DIFF_W-1:0] dx, dy;
    logic                     left_half;

    // Difference vector in 16 bits, no overflow possible
    assign dx = DIFF_W'(arrive_x) - DIFF_W'(depart_x);
    assign dy = DIFF_W'(arrive_y) - DIFF_W'(depart_y);

    // Left half-plane: negate and start from half a turn
    assign left_half = dx[DIFF_W-1];

    always_comb
    begin
        item.dx          = left_half ? -dx : dx;
        item.dy          = left_half ? -dy : dy;
        item.half_turn   = left_half;
        item.zero_vector = (dx == '0) && (dy == '0);
    end

endmodule

`default_nettype wire

>>> sv/vhd_back.sv
// Back end: unrolled vectoring CORDIC pipeline and scaling to 1/64 degree.
`timescale 1ns / 1ps
`default_nettype none

module vhd_back #(
    parameter int CORDIC_STEPS = vhd_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vhd_pkg::vec_item_t item,
    input  wire logic               item_valid,
    output logic                    item_pop,
    output vhd_pkg::result_t        res,
    output logic                    res_push,
    input  wire logic               res_full
);

    import vhd_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    logic signed [DP_W-1:0] x_reg   [NSTEPS+1];
    logic signed [DP_W-1:0] y_reg   [NSTEPS+1];
    logic [ACC_W-1:0]       acc_reg [NSTEPS+1];
    logic                   zero_reg [NSTEPS+1];
    logic                   vld_reg  [NSTEPS+1];

    logic [MUL_W-1:0]       prod_reg;
    logic                   prod_zero_reg;
    logic                   prod_vld_reg;

    logic                   en;
    logic [MUL_W-1:0]       rounded;
    logic [HEAD_W-1:0]      head_raw;

    // Whole pipeline moves together unless the result queue is full
    assign en       = !res_full;
    assign item_pop = en && item_valid;

    // Load stage: scale by 2^16 and set the starting angle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= {{(DP_W - DIFF_W - FRAC_W){item.dx[DIFF_W-1]}}, item.dx,
                            FRAC_W'(0)};
            y_reg[0]    <= {{(DP_W - DIFF_W - FRAC_W){item.dy[DIFF_W-1]}}, item.dy,
                            FRAC_W'(0)};
            acc_reg[0]  <= item.half_turn ? HALF_TURN_ANGLE : '0;
            zero_reg[0] <= item.zero_vector;
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_step
        logic signed [DP_W-1:0] xs, ys;
        logic signed [DP_W-1:0] x_next, y_next;
        logic [ACC_W-1:0]       acc_next;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_comb
        begin
            if (y_reg[i] > 0)
            begin
                x_next   = x_reg[i] + ys;
                y_next   = y_reg[i] - xs;
                acc_next = acc_reg[i] + ATAN_TABLE[i];
            end
            else
            begin
                x_next   = x_reg[i] - ys;
                y_next   = y_reg[i] + xs;
                acc_next = acc_reg[i] - ATAN_TABLE[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                acc_reg[i+1]  <= acc_next;
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Scale the binary angle to 1/64 degree units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            prod_vld_reg <= vld_reg[NSTEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg      <= MUL_W'(acc_reg[NSTEPS]) * MUL_W'(FULL_TURN_UNITS);
            prod_zero_reg <= zero_reg[NSTEPS];
        end
    end

    // Round to nearest, wrap a full turn back to zero and give zero for a zero vector
    assign rounded  = prod_reg + ROUND_HALF;
    assign head_raw = rounded[MUL_W-1:ACC_W];

    always_comb
    begin
        res.zero_vector = prod_zero_reg;
        if (prod_zero_reg || (head_raw >= FULL_TURN_UNITS))
        begin
            res.heading = '0;
        end
        else
        begin
            res.heading = head_raw;
        end
    end

    assign res_push = en && prod_vld_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en && prod_vld_reg |=> prod_vld_reg && $stable(prod_reg))
        else $error("stalled result lost from the scaling stage");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res.heading < FULL_TURN_UNITS)
        else $error("heading outside one turn");

    a_zero_head: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.zero_vector |-> res.heading == '0)
        else $error("zero vector with nonzero heading");

endmodule

`default_nettype wire

>>> tb/vector_heading_degrees_tb.sv
// Self-checking testbench for the vector heading block: predicted headings vs. DUT results.
`timescale 1ns / 1ps

module vector_heading_degrees_tb;

    localparam int N_STEPS      = vhd_pkg::CORDIC_STEPS_DEF;
    localparam int ARCTAN_LEN   = 24;
    localparam int TURN_UNITS   = 23040;
    localparam int COORD_MIN    = -16384;
    localparam int COORD_MAX    = 16383;
    localparam int REPORT_LIMIT = 10;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32
    localparam logic [31:0] ARCTAN_TURN [ARCTAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                push        = 1'b0;
    logic                                pop         = 1'b0;
    logic signed [vhd_pkg::COORD_W-1:0]  depart_x    = '0;
    logic signed [vhd_pkg::COORD_W-1:0]  depart_y    = '0;
    logic signed [vhd_pkg::COORD_W-1:0]  arrive_x    = '0;
    logic signed [vhd_pkg::COORD_W-1:0]  arrive_y    = '0;
    logic                                full;
    logic                                empty;
    logic [vhd_pkg::HEAD_W-1:0]          heading;
    logic                                zero_vector;

    vhd_pkg::result_t expected_heading_q[$];
    vhd_pkg::result_t head_want;
    int               mismatch_count = 0;
    bit               feed_idle_on   = 1'b0;
    bit               drain_stall_on = 1'b0;

    vector_heading_degrees #(
        .CORDIC_STEPS (N_STEPS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .depart_x    (depart_x),
        .depart_y    (depart_y),
        .arrive_x    (arrive_x),
        .arrive_y    (arrive_y),
        .empty       (empty),
        .pop         (pop),
        .heading     (heading),
        .zero_vector (zero_vector)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Heading of (arrive - depart) by vectoring CORDIC, 1/64 degree units
    function automatic vhd_pkg::result_t predict_heading(
        input logic signed [vhd_pkg::COORD_W-1:0] dep_x,
        input logic signed [vhd_pkg::COORD_W-1:0] dep_y,
        input logic signed [vhd_pkg::COORD_W-1:0] arr_x,
        input logic signed [vhd_pkg::COORD_W-1:0] arr_y
    );
        vhd_pkg::result_t res;
        int               vec_dx;
        int               vec_dy;
        int               steps;
        longint           x;
        longint           y;
        longint           xs;
        longint           ys;
        logic [31:0]      angle;
        logic [63:0]      units;

        vec_dx = int'(arr_x) - int'(dep_x);
        vec_dy = int'(arr_y) - int'(dep_y);
        res.heading     = '0;
        res.zero_vector = 1'b0;
        if (vec_dx == 0 && vec_dy == 0)
        begin
            res.zero_vector = 1'b1;
            return res;
        end

        // fold left half-plane onto the right, start at half a turn
        x     = longint'(vec_dx) * 65536;
        y     = longint'(vec_dy) * 65536;
        angle = 32'h0;
        if (x < 0)
        begin
            x     = -x;
            y     = -y;
            angle = 32'h8000_0000;
        end

        steps = (N_STEPS > ARCTAN_LEN) ? ARCTAN_LEN : N_STEPS;
        for (int i = 0; i < steps; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x     = x + ys;
                y     = y - xs;
                angle = angle + ARCTAN_TURN[i];
            end
            else
            begin
                x     = x - ys;
                y     = y + xs;
                angle = angle - ARCTAN_TURN[i];
            end
        end

        // binary angle to 1/64 degree, rounded; full turn wraps to 0
        units = ({32'h0, angle} * 64'd23040 + 64'h8000_0000) >> 32;
        if (units >= 64'(TURN_UNITS))
            units = 64'h0;
        res.heading = units[vhd_pkg::HEAD_W-1:0];
        return res;
    endfunction

    // Transaction monitor: predict on accept, compare on pop
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                expected_heading_q.push_back(
                    predict_heading(depart_x, depart_y, arrive_x, arrive_y));
            if (pop && !empty)
            begin
                if (expected_heading_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: heading=%0d zero_vector=%0b",
                                 heading, zero_vector);
                end
                else
                begin
                    head_want = expected_heading_q.pop_front();
                    if (heading !== head_want.heading ||
                        zero_vector !== head_want.zero_vector)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: heading exp=%0d act=%0d, zero_vector exp=%0b act=%0b",
                                     head_want.heading, heading,
                                     head_want.zero_vector, zero_vector);
                    end
                end
            end
        end
    end

    // Result side: pop with random stall bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                pop <= 1'b0;
            else if (drain_stall_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // Send one transaction; returns right after the accepting edge
    task automatic send_vector(input int dep_x, input int dep_y,
                               input int arr_x, input int arr_y);
        if (feed_idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push     <= 1'b1;
        depart_x <= vhd_pkg::COORD_W'(dep_x);
        depart_y <= vhd_pkg::COORD_W'(dep_y);
        arrive_x <= vhd_pkg::COORD_W'(arr_x);
        arrive_y <= vhd_pkg::COORD_W'(arr_y);
        do
            @(posedge clk);
        while (full);
    endtask

    // Coordinate near base, kept inside the field range
    function automatic int near_coord(input int base, input int span);
        int c;
        c = base + int'($urandom_range(0, 2 * span)) - span;
        if (c < COORD_MIN)
            c = COORD_MIN;
        if (c > COORD_MAX)
            c = COORD_MAX;
        return c;
    endfunction

    // One random transaction from a mix of vector shapes
    task automatic send_random_vector();
        int kind;
        int bx;
        int by;
        kind = $urandom_range(0, 9);
        bx   = int'($urandom_range(0, 32767)) + COORD_MIN;
        by   = int'($urandom_range(0, 32767)) + COORD_MIN;
        case (kind)
            0:       send_vector(bx, by, bx, by);
            1:       send_vector(bx, by, near_coord(bx, 2000), by);
            2:       send_vector(bx, by, bx, near_coord(by, 2000));
            3, 4:    send_vector(bx, by, near_coord(bx, 4), near_coord(by, 4));
            5:       send_vector(bx, by, near_coord(bx, 300), near_coord(by, 300));
            default: send_vector(bx, by, int'($urandom_range(0, 32767)) + COORD_MIN,
                                 int'($urandom_range(0, 32767)) + COORD_MIN);
        endcase
    endtask

    // Extremes, axes, quadrants, zero vectors and the wrap to zero
    task automatic test_corner_vectors();
        send_vector(0, 0, 0, 0);
        send_vector(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_vector(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_vector(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_vector(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_vector(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_vector(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_vector(0, 0, 1, 0);
        send_vector(0, 0, 0, 1);
        send_vector(0, 0, -1, 0);
        send_vector(0, 0, 0, -1);
        send_vector(0, 0, 5, 5);
        send_vector(0, 0, -5, 5);
        send_vector(0, 0, -5, -5);
        send_vector(0, 0, 5, -5);
        send_vector(COORD_MIN, 0, COORD_MAX, 0);
        send_vector(COORD_MAX, 0, COORD_MIN, 0);
        send_vector(0, COORD_MIN, 0, COORD_MAX);
        send_vector(0, COORD_MAX, 0, COORD_MIN);
        // just below a full turn rounds up to zero; also just above zero and either side of half a turn
        send_vector(COORD_MIN, 1, COORD_MAX, 0);
        send_vector(COORD_MIN, 0, COORD_MAX, 1);
        send_vector(COORD_MAX, 0, COORD_MIN, 1);
        send_vector(COORD_MAX, 1, COORD_MIN, 0);
    endtask

    // Random vectors with idling toggled on and off in blocks
    task automatic test_random_vectors();
        for (int blk = 0; blk < 10; blk++)
        begin
            feed_idle_on   = (blk % 3) != 2;
            drain_stall_on = (blk % 4) != 3;
            repeat (100) send_random_vector();
        end
    endtask

    // Closing stretch at full rate, no idling on either side
    task automatic test_back_to_back();
        feed_idle_on   = 1'b0;
        drain_stall_on = 1'b0;
        repeat (200) send_random_vector();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        feed_idle_on   = 1'b1;
        drain_stall_on = 1'b1;
        test_corner_vectors();
        test_random_vectors();
        test_back_to_back();

        // drain and let the pipeline settle
        push <= 1'b0;
        while (expected_heading_q.size() != 0)
            @(posedge clk);
        repeat (N_STEPS + 10) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
